[rtl/core/bpc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    typedef enum logic [1:0] {
        CFG_TEMP     = 2'd0,
        CFG_PRESS_LO = 2'd1,
        CFG_PRESS_HI = 2'd2,
        CFG_PRESS_P9 = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coeffs;

    // front end -> divider
    typedef struct packed {
        logic        [63:0] num;
        logic signed [30:0] den;
        logic        [23:0] temp;
    } t_div_req;

    // divider -> back end
    typedef struct packed {
        logic [63:0] quot;
        logic        neg;
        logic        zero;
        logic [23:0] temp;
    } t_div_rsp;

    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] press;
        logic        pvalid;
    } t_result;

    localparam int          T_OFFSET   = 128000;
    localparam logic [31:0] TEMP_ROUND = 32'd128;
    localparam logic [20:0] P_BASE     = 21'd1048576;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [63:0] BIAS47     = 64'h0000_8000_0000_0000;

endpackage

`default_nettype wire

[rtl/core/bpc_if.sv]
// Valid/ready channel interfaces: sample input, result output, config write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    modport source (output valid, raw_temp, raw_press, input ready);
    modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface bpc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] temp_centideg;
    logic [31:0] pressure_q24_8;
    logic        press_valid;
    modport source (output valid, temp_centideg, pressure_q24_8, press_valid, input ready);
    modport sink   (input valid, temp_centideg, pressure_q24_8, press_valid, output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/bpc_cfg_regs.sv]
// Calibration coefficient register bank, unpacked into a coefficient struct.
// Depends on bpc_pkg and bpc_if.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs import bpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_cfg_if.sink    cfg,
    output t_coeffs    o_coef
);

    logic [47:0] r_temp;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [15:0] r_p9;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_plo  <= '0;
            r_phi  <= '0;
            r_p9   <= '0;
        end else if (cfg.valid) begin
            case (t_cfg_idx'(cfg.index))
                CFG_TEMP:     r_temp <= cfg.data[47:0];
                CFG_PRESS_LO: r_plo  <= cfg.data;
                CFG_PRESS_HI: r_phi  <= cfg.data;
                CFG_PRESS_P9: r_p9   <= cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_coef.t1 = r_temp[15:0];
    assign o_coef.t2 = r_temp[31:16];
    assign o_coef.t3 = r_temp[47:32];
    assign o_coef.p1 = r_plo[15:0];
    assign o_coef.p2 = r_plo[31:16];
    assign o_coef.p3 = r_plo[47:32];
    assign o_coef.p4 = r_plo[63:48];
    assign o_coef.p5 = r_phi[15:0];
    assign o_coef.p6 = r_phi[31:16];
    assign o_coef.p7 = r_phi[47:32];
    assign o_coef.p8 = r_phi[63:48];
    assign o_coef.p9 = r_p9;

endmodule

`default_nettype wire

[rtl/core/bpc_front.sv]
// Temperature path and pressure pre-division terms, 12 pipeline stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_front import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_coeffs     i_coef,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_raw_temp,
    input  logic [19:0] i_raw_press,
    output logic        o_valid,
    input  logic        i_ready,
    output t_div_req    o_req
);

    localparam int NST = 12;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] adv;

    // stall collapses bubbles: a stage moves if empty or its successor moves
    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign n_v     = {r_v[NST-2:0], i_valid};
    assign o_ready = adv[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) r_v[k] <= n_v[k];
            end
        end
    end

    // stage 1
    logic [31:0] n_a, n_d;
    logic [31:0] r_s1_a, r_s1_d;
    logic [19:0] r_s1_p;
    assign n_a = {15'd0, i_raw_temp[19:3]} - {15'd0, i_coef.t1, 1'b0};
    assign n_d = {16'd0, i_raw_temp[19:4]} - {16'd0, i_coef.t1};

    // stage 2
    logic signed [31:0] n_t2x;
    logic [31:0] n_m1, n_dd;
    logic [31:0] r_s2_m1, r_s2_dd;
    logic [19:0] r_s2_p;
    assign n_t2x = i_coef.t2;
    assign n_m1  = r_s1_a * n_t2x;
    assign n_dd  = r_s1_d * r_s1_d;

    // stage 3
    logic signed [31:0] n_v1, n_dds, n_t3x;
    logic [31:0] n_m3;
    logic signed [31:0] r_s3_v1;
    logic [31:0] r_s3_m3;
    logic [19:0] r_s3_p;
    assign n_v1  = $signed(r_s2_m1) >>> 11;
    assign n_dds = $signed(r_s2_dd) >>> 12;
    assign n_t3x = i_coef.t3;
    assign n_m3  = n_dds * n_t3x;

    // stage 4: fine temperature
    logic signed [31:0] n_v2, n_tf;
    logic signed [31:0] r_s4_tf;
    logic [19:0] r_s4_p;
    assign n_v2 = $signed(r_s3_m3) >>> 14;
    assign n_tf = r_s3_v1 + n_v2;

    // stage 5
    logic [31:0] n_t5;
    logic signed [31:0] n_t5s;
    logic signed [33:0] n_q1;
    logic signed [33:0] r_s5_q1;
    logic [23:0] r_s5_temp;
    logic [19:0] r_s5_p;
    assign n_t5  = r_s4_tf * 32'd5 + TEMP_ROUND;
    assign n_t5s = $signed(n_t5) >>> 8;
    assign n_q1  = 34'(r_s4_tf) - 34'(T_OFFSET);

    // stage 6
    logic signed [67:0] n_sq;
    logic signed [49:0] n_q1p5, n_q1p2;
    logic [63:0] n_b, n_e;
    logic [63:0] r_s6_s, r_s6_b, r_s6_e;
    logic [23:0] r_s6_temp;
    logic [19:0] r_s6_p;
    assign n_sq   = r_s5_q1 * r_s5_q1;
    assign n_q1p5 = r_s5_q1 * i_coef.p5;
    assign n_q1p2 = r_s5_q1 * i_coef.p2;
    assign n_b    = {n_q1p5[46:0], 17'd0};
    assign n_e    = {{2{n_q1p2[49]}}, n_q1p2, 12'd0};

    // stage 7: 64 x 16 partial products
    logic signed [31:0] n_p6x, n_p3x;
    logic signed [48:0] n_pl6, n_pl3;
    logic [31:0] n_ph6, n_ph3;
    logic signed [48:0] r_s7_pl6, r_s7_pl3;
    logic [31:0] r_s7_ph6, r_s7_ph3;
    logic [63:0] r_s7_b, r_s7_e;
    logic [23:0] r_s7_temp;
    logic [19:0] r_s7_p;
    assign n_p6x = i_coef.p6;
    assign n_p3x = i_coef.p3;
    assign n_pl6 = $signed({1'b0, r_s6_s[31:0]}) * i_coef.p6;
    assign n_pl3 = $signed({1'b0, r_s6_s[31:0]}) * i_coef.p3;
    assign n_ph6 = r_s6_s[63:32] * n_p6x;
    assign n_ph3 = r_s6_s[63:32] * n_p3x;

    // stage 8
    logic [63:0] n_aa, n_s3;
    logic [63:0] r_s8_aa, r_s8_s3, r_s8_b, r_s8_e;
    logic [23:0] r_s8_temp;
    logic [19:0] r_s8_p;
    assign n_aa = 64'(r_s7_pl6) + {r_s7_ph6, 32'd0};
    assign n_s3 = 64'(r_s7_pl3) + {r_s7_ph3, 32'd0};

    // stage 9
    logic [63:0] n_c, n_q2, n_x;
    logic signed [63:0] n_s3sh;
    logic [63:0] r_s9_q2, r_s9_x;
    logic [23:0] r_s9_temp;
    logic [19:0] r_s9_p;
    assign n_c    = {{13{i_coef.p4[15]}}, i_coef.p4, 35'd0};
    assign n_q2   = r_s8_aa + r_s8_b + n_c;
    assign n_s3sh = $signed(r_s8_s3) >>> 8;
    assign n_x    = n_s3sh + r_s8_e + BIAS47;

    // stage 10
    logic [20:0] n_p0;
    logic [63:0] n_num0;
    logic [47:0] n_pl1;
    logic [31:0] n_ph1;
    logic [63:0] r_s10_num;
    logic [47:0] r_s10_pl1;
    logic [31:0] r_s10_ph1;
    logic [23:0] r_s10_temp;
    assign n_p0   = P_BASE - {1'b0, r_s9_p};
    assign n_num0 = {12'd0, n_p0, 31'd0} - r_s9_q2;
    assign n_pl1  = r_s9_x[31:0] * i_coef.p1;
    assign n_ph1  = r_s9_x[63:32] * {16'd0, i_coef.p1};

    // stage 11
    logic [63:0] n_f;
    logic [43:0] n_nl;
    logic [31:0] n_nh;
    logic [63:0] r_s11_f;
    logic [43:0] r_s11_nl;
    logic [31:0] r_s11_nh;
    logic [23:0] r_s11_temp;
    assign n_f  = {16'd0, r_s10_pl1} + {r_s10_ph1, 32'd0};
    assign n_nl = r_s10_num[31:0] * P_SCALE[11:0];
    assign n_nh = r_s10_num[63:32] * P_SCALE;

    // stage 12: divider request register
    t_div_req r_s12;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_a <= n_a;
            r_s1_d <= n_d;
            r_s1_p <= i_raw_press;
        end
        if (adv[1]) begin
            r_s2_m1 <= n_m1;
            r_s2_dd <= n_dd;
            r_s2_p  <= r_s1_p;
        end
        if (adv[2]) begin
            r_s3_v1 <= n_v1;
            r_s3_m3 <= n_m3;
            r_s3_p  <= r_s2_p;
        end
        if (adv[3]) begin
            r_s4_tf <= n_tf;
            r_s4_p  <= r_s3_p;
        end
        if (adv[4]) begin
            r_s5_q1   <= n_q1;
            r_s5_temp <= n_t5s[23:0];
            r_s5_p    <= r_s4_p;
        end
        if (adv[5]) begin
            r_s6_s    <= n_sq[63:0];
            r_s6_b    <= n_b;
            r_s6_e    <= n_e;
            r_s6_temp <= r_s5_temp;
            r_s6_p    <= r_s5_p;
        end
        if (adv[6]) begin
            r_s7_pl6  <= n_pl6;
            r_s7_pl3  <= n_pl3;
            r_s7_ph6  <= n_ph6;
            r_s7_ph3  <= n_ph3;
            r_s7_b    <= r_s6_b;
            r_s7_e    <= r_s6_e;
            r_s7_temp <= r_s6_temp;
            r_s7_p    <= r_s6_p;
        end
        if (adv[7]) begin
            r_s8_aa   <= n_aa;
            r_s8_s3   <= n_s3;
            r_s8_b    <= r_s7_b;
            r_s8_e    <= r_s7_e;
            r_s8_temp <= r_s7_temp;
            r_s8_p    <= r_s7_p;
        end
        if (adv[8]) begin
            r_s9_q2   <= n_q2;
            r_s9_x    <= n_x;
            r_s9_temp <= r_s8_temp;
            r_s9_p    <= r_s8_p;
        end
        if (adv[9]) begin
            r_s10_num  <= n_num0;
            r_s10_pl1  <= n_pl1;
            r_s10_ph1  <= n_ph1;
            r_s10_temp <= r_s9_temp;
        end
        if (adv[10]) begin
            r_s11_f    <= n_f;
            r_s11_nl   <= n_nl;
            r_s11_nh   <= n_nh;
            r_s11_temp <= r_s10_temp;
        end
        if (adv[11]) begin
            r_s12.num  <= {20'd0, r_s11_nl} + {r_s11_nh, 32'd0};
            r_s12.den  <= r_s11_f[63:33];
            r_s12.temp <= r_s11_temp;
        end
    end

    assign o_req = r_s12;

endmodule

`default_nettype wire

[rtl/core/bpc_div.sv]
// Pipelined signed 64 / 31 bit divider, two quotient bits per stage.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_div import bpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_div_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_div_rsp o_rsp
);

    localparam int STEPS = 2;
    localparam int NSTG  = 64 / STEPS;

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] dvd;   // dividend bits shift out, quotient bits shift in
        logic [30:0] dvs;
        logic        neg;
        logic        zero;
        logic [23:0] temp;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st s);
        t_div_st     res;
        logic [31:0] trial;
        res   = s;
        trial = {s.rem, s.dvd[63]};
        res.dvd = {s.dvd[62:0], 1'b0};
        if (trial >= {1'b0, s.dvs}) begin
            trial      = trial - {1'b0, s.dvs};
            res.dvd[0] = 1'b1;
        end
        res.rem = trial[30:0];
        return res;
    endfunction

    logic [NSTG:0] r_v;
    logic [NSTG:0] n_v;
    logic [NSTG:0] adv;
    t_div_st       r_st [0:NSTG];
    t_div_st       n_st [0:NSTG];

    always_comb begin
        adv[NSTG] = !r_v[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign n_v     = {r_v[NSTG-1:0], i_valid};
    assign o_ready = adv[0];
    assign o_valid = r_v[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k <= NSTG; k++) begin
                if (adv[k]) r_v[k] <= n_v[k];
            end
        end
    end

    // sign and magnitude split
    always_comb begin
        n_st[0].rem  = '0;
        n_st[0].dvd  = i_req.num[63] ? (64'd0 - i_req.num) : i_req.num;
        n_st[0].dvs  = i_req.den[30] ? (~i_req.den + 31'd1) : i_req.den;
        n_st[0].neg  = i_req.num[63] ^ i_req.den[30];
        n_st[0].zero = (i_req.den == 31'sd0);
        n_st[0].temp = i_req.temp;
    end

    for (genvar g = 1; g <= NSTG; g++) begin : g_stage
        always_comb begin
            n_st[g] = r_st[g-1];
            for (int j = 0; j < STEPS; j++) begin
                n_st[g] = div_step(n_st[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NSTG; k++) begin
            if (adv[k]) r_st[k] <= n_st[k];
        end
    end

    assign o_rsp.quot = r_st[NSTG].dvd;
    assign o_rsp.neg  = r_st[NSTG].neg;
    assign o_rsp.zero = r_st[NSTG].zero;
    assign o_rsp.temp = r_st[NSTG].temp;

endmodule

`default_nettype wire

[rtl/core/bpc_back.sv]
// Post-division pressure terms and result register, 8 pipeline stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_back import bpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_coeffs  i_coef,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_div_rsp i_rsp,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);

    localparam int NST = 8;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign n_v     = {r_v[NST-2:0], i_valid};
    assign o_ready = adv[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) r_v[k] <= n_v[k];
            end
        end
    end

    // temperature and zero-divisor flag ride along every stage
    logic [23:0] r_temp [0:NST-2];
    logic        r_zero [0:NST-2];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_temp[0] <= i_rsp.temp;
            r_zero[0] <= i_rsp.zero;
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (adv[k]) begin
                r_temp[k] <= r_temp[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // stage 0: signed quotient
    logic [63:0] r_b0_p;

    // stage 1
    logic signed [31:0] n_p8x;
    logic signed [48:0] n_pl8;
    logic [31:0] n_ph8;
    logic signed [50:0] r_b1_h;
    logic signed [48:0] r_b1_pl8;
    logic [31:0] r_b1_ph8;
    logic [63:0] r_b1_p;
    assign n_p8x = i_coef.p8;
    assign n_pl8 = $signed({1'b0, r_b0_p[31:0]}) * i_coef.p8;
    assign n_ph8 = r_b0_p[63:32] * n_p8x;

    // stage 2: h squared partials
    logic signed [31:0] n_hhx;
    logic [63:0] n_hll;
    logic [31:0] n_hx;
    logic [63:0] r_b2_q2, r_b2_hll, r_b2_p;
    logic [31:0] r_b2_hx;
    assign n_hhx = $signed(r_b1_h[50:32]);
    assign n_hll = r_b1_h[31:0] * r_b1_h[31:0];
    assign n_hx  = r_b1_h[31:0] * n_hhx;

    // stage 3
    logic [63:0] r_b3_hh, r_b3_p;
    logic signed [63:0] r_b3_q2b;

    // stage 4
    logic signed [31:0] n_p9x;
    logic signed [48:0] n_pl9;
    logic [31:0] n_ph9;
    logic signed [48:0] r_b4_pl9;
    logic [31:0] r_b4_ph9;
    logic [63:0] r_b4_p;
    logic signed [63:0] r_b4_q2b;
    assign n_p9x = i_coef.p9;
    assign n_pl9 = $signed({1'b0, r_b3_hh[31:0]}) * i_coef.p9;
    assign n_ph9 = r_b3_hh[63:32] * n_p9x;

    // stage 5
    logic [63:0] r_b5_m, r_b5_p;
    logic signed [63:0] r_b5_q2b;

    // stage 6
    logic signed [63:0] n_q1c;
    logic [63:0] r_b6_sum;
    assign n_q1c = $signed(r_b5_m) >>> 25;

    // stage 7: result
    logic [31:0] n_p7s;
    t_result     r_b7;
    assign n_p7s = {{12{i_coef.p7[15]}}, i_coef.p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_b0_p <= i_rsp.neg ? (64'd0 - i_rsp.quot) : i_rsp.quot;
        end
        if (adv[1]) begin
            r_b1_h   <= r_b0_p[63:13];
            r_b1_pl8 <= n_pl8;
            r_b1_ph8 <= n_ph8;
            r_b1_p   <= r_b0_p;
        end
        if (adv[2]) begin
            r_b2_q2  <= 64'(r_b1_pl8) + {r_b1_ph8, 32'd0};
            r_b2_hll <= n_hll;
            r_b2_hx  <= n_hx;
            r_b2_p   <= r_b1_p;
        end
        if (adv[3]) begin
            r_b3_hh  <= r_b2_hll + {r_b2_hx[30:0], 33'd0};
            r_b3_q2b <= $signed(r_b2_q2) >>> 19;
            r_b3_p   <= r_b2_p;
        end
        if (adv[4]) begin
            r_b4_pl9 <= n_pl9;
            r_b4_ph9 <= n_ph9;
            r_b4_p   <= r_b3_p;
            r_b4_q2b <= r_b3_q2b;
        end
        if (adv[5]) begin
            r_b5_m   <= 64'(r_b4_pl9) + {r_b4_ph9, 32'd0};
            r_b5_p   <= r_b4_p;
            r_b5_q2b <= r_b4_q2b;
        end
        if (adv[6]) begin
            r_b6_sum <= r_b5_p + n_q1c + r_b5_q2b;
        end
        if (adv[7]) begin
            r_b7.temp   <= r_temp[NST-2];
            r_b7.press  <= r_zero[NST-2] ? 32'd0 : (r_b6_sum[39:8] + n_p7s);
            r_b7.pvalid <= !r_zero[NST-2];
        end
    end

    assign o_res = r_b7;

endmodule

`default_nettype wire

[rtl/core/baro_temp_press_compensation.sv]
// Pipeline: 12 front stages, 33 divider stages and 8 back stages.
// Throughput: one pair per cycle while the output sink is not stalling.
// The 64-bit divider retires two quotient bits per stage and sets the depth.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and sets every
// calibration register to zero. Depends on bpc_pkg, bpc_if and the bpc_* cores.
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_press_compensation import bpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);

    // Coefficients are to be held static by the user while items are in flight
    // (not enforced here); stages read them directly instead of carried copies.
    t_coeffs  coef;

    // front -> divider -> back, each hop a valid/ready pair
    logic     fd_valid, fd_ready;
    t_div_req fd_req;
    logic     db_valid, db_ready;
    t_div_rsp db_rsp;
    t_result  res;

    bpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (i_cfg),
        .o_coef  (coef)
    );

    // Temperature path, fine-temperature term, then divisor and dividend.
    bpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (coef),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_raw_temp  (i_in.raw_temp),
        .i_raw_press (i_in.raw_press),
        .o_valid     (fd_valid),
        .i_ready     (fd_ready),
        .o_req       (fd_req)
    );

    // Signed truncating division; a zero divisor is flagged and the quotient
    // ignored downstream.
    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fd_valid),
        .o_ready (fd_ready),
        .i_req   (fd_req),
        .o_valid (db_valid),
        .i_ready (db_ready),
        .o_rsp   (db_rsp)
    );

    // Second-order pressure terms; last stage is the output register.
    bpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_valid (db_valid),
        .o_ready (db_ready),
        .i_rsp   (db_rsp),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.temp_centideg  = res.temp;
    assign o_out.pressure_q24_8 = res.press;
    assign o_out.press_valid    = res.pvalid;

`ifndef SYNTHESIS
    // invalid pressure must be forced to zero
    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.press_valid) |-> (o_out.pressure_q24_8 == 32'd0))
        else $error("invalid pressure result not zero");

    // an accepting sink must open the whole pipe
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output is drained");

    // input may only stall behind a blocked, full output stage
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire
